// ===== rtl/ipv4fhg_pkg.sv =====
// Shared types, constants and helpers of the IPv4 fragment header generator.
package ipv4fhg_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MTU      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_OK = 1'b1;
  localparam logic [15:0] MTU_RESET      = 16'd1500;
  localparam logic        BCAST_OK_RESET = 1'b1;

  // Header layout
  localparam logic [15:0] HDR_LEN      = 16'd20;
  localparam logic [15:0] MIN_FRAG_MTU = 16'd28;   // header plus one 8-byte block
  localparam logic [15:0] PIECE_MASK   = 16'hFFF8; // round down to 8 bytes
  localparam logic [15:0] DF_MASK      = 16'h4000;
  localparam logic [15:0] MF_MASK      = 16'h2000;
  localparam int          FLAG_MF      = 13;
  localparam logic [7:0]  VER_IHL      = 8'h45;
  localparam int          MAX_FRAGS_LOG2 = 6;      // at most 64 fragments

  // Checksum accumulator: nine 16-bit words
  localparam int SUM_W = 20;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_BCAST = 2'd2
  } status_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic        forwarding;
    logic [7:0]  tos;
    logic [15:0] total_len;
    logic [15:0] ident_in;
    logic [15:0] flags_offset_in;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        dst_is_broadcast;
  } hdr_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] ident_out;
    logic [15:0] flags_offset_out;
    logic [15:0] frag_total_len;
    logic [15:0] header_checksum;
    logic        last;
  } res_t;

  // Classified request handed from front to back
  typedef struct packed {
    status_t     status;
    logic        frag;      // needs splitting
    logic [15:0] ident;
    logic [15:0] offw;
    logic [15:0] tlen;
    logic [15:0] payload;
    logic [15:0] piece;
    logic [7:0]  tos;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [17:0] addr_sum;  // sum of the four address words
  } job_t;

  // End-around carry fold of a ones complement sum
  function automatic logic [15:0] csum_fold(input logic [SUM_W-1:0] s);
    logic [16:0] t;
    t = 17'(s[15:0]) + 17'(s[SUM_W-1:16]);
    return t[15:0] + 16'(t[16]);
  endfunction

endpackage

// ===== rtl/ipv4fhg_if.sv =====
// Request and result channel interfaces of the IPv4 fragment header generator.
interface ipv4fhg_hdr_if;
  import ipv4fhg_pkg::*;
  logic valid;
  logic ready;
  hdr_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ipv4fhg_res_if;
  import ipv4fhg_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/ipv4fhg_front.sv =====
// Front end: accepts header requests, assigns identification and classifies them.
module ipv4fhg_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        mtu,
  input  logic               broadcast_ok,
  ipv4fhg_hdr_if.sink        hdr,
  input  logic               q_full,
  output logic               q_push,
  output ipv4fhg_pkg::job_t  q_data
);
  import ipv4fhg_pkg::*;

  logic [15:0] ident_counter;
  hdr_t        h;
  logic [15:0] offw;
  logic [15:0] piece;
  logic [15:0] payload;
  logic [21:0] span;
  logic        fits;

  assign hdr.ready = !q_full;
  assign q_push    = hdr.valid && !q_full;

  // Classification of the request at the port
  always_comb begin
    h       = hdr.payload;
    offw    = h.forwarding ? h.flags_offset_in : (h.flags_offset_in & DF_MASK);
    piece   = (mtu - HDR_LEN) & PIECE_MASK;
    payload = h.total_len - HDR_LEN;
    span    = 22'(piece) << MAX_FRAGS_LOG2;
    fits    = h.total_len <= mtu;

    q_data.frag     = 1'b0;
    q_data.status   = ST_OK;
    q_data.ident    = h.forwarding ? h.ident_in : ident_counter;
    q_data.offw     = offw;
    q_data.tlen     = h.total_len;
    q_data.payload  = payload;
    q_data.piece    = piece;
    q_data.tos      = h.tos;
    q_data.ttl      = h.ttl;
    q_data.protocol = h.protocol;
    q_data.addr_sum = 18'(h.src_addr[31:16]) + 18'(h.src_addr[15:0])
                    + 18'(h.dst_addr[31:16]) + 18'(h.dst_addr[15:0]);

    priority if (h.dst_is_broadcast && !broadcast_ok) begin
      q_data.status = ST_NO_BCAST;
    end else if (h.dst_is_broadcast && !fits) begin
      q_data.status = ST_TOO_BIG;
    end else if (fits) begin
      q_data.status = ST_OK;
    end else if ((offw & DF_MASK) != 16'd0) begin
      q_data.status = ST_TOO_BIG;
    end else if (mtu < MIN_FRAG_MTU) begin
      q_data.status = ST_TOO_BIG;
    end else if (22'(payload) > span) begin
      // more than the fragment limit
      q_data.status = ST_TOO_BIG;
    end else begin
      q_data.frag = 1'b1;
    end
  end

  // Identification counter, advanced by every local request
  always_ff @(posedge clk) begin
    if (rst) begin
      ident_counter <= 16'd0;
    end else if (q_push && !hdr.payload.forwarding) begin
      ident_counter <= ident_counter + 16'd1;
    end
  end

  a_ident_step: assert property (@(posedge clk) disable iff (rst)
    (q_push && !hdr.payload.forwarding) |=> ident_counter == $past(ident_counter) + 16'd1)
    else $error("identification counter did not advance on a local request");

endmodule

// ===== rtl/ipv4fhg_fifo.sv =====
// Short queue of classified requests between front and back end.
module ipv4fhg_fifo #(
  parameter int DEPTH = ipv4fhg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ipv4fhg_pkg::job_t  push_data,
  output logic               full,
  input  logic               pop,
  output ipv4fhg_pkg::job_t  pop_data,
  output logic               empty
);
  import ipv4fhg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == CNT_W'(0);
  assign pop_data = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("request queue holds more than its depth");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("request queue popped while empty");

endmodule

// ===== rtl/ipv4fhg_back.sv =====
// Back end: walks each request through its fragments and builds the headers.
module ipv4fhg_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_pop,
  input  ipv4fhg_pkg::job_t  q_data,
  ipv4fhg_res_if.source      res
);
  import ipv4fhg_pkg::*;

  seq_state_t       state;
  seq_state_t       state_next;
  job_t             job;
  logic [15:0]      pos;
  logic [SUM_W-1:0] base;

  // fragment stage
  logic             f_valid;
  status_t          f_status;
  logic [15:0]      f_ident;
  logic [15:0]      f_fo;
  logic [15:0]      f_flen;
  logic [SUM_W-1:0] f_base;
  logic             f_last;

  logic             o_free;
  logic             f_free;
  logic             emit;
  logic             done;
  logic [16:0]      pos_end;
  logic             lastp;
  status_t          e_status;
  logic [15:0]      e_ident;
  logic [15:0]      e_fo;
  logic [15:0]      e_flen;
  logic             e_last;
  logic [SUM_W-1:0] o_sum;

  assign o_free = !res.valid || res.ready;
  assign f_free = !f_valid || o_free;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    unique case (state)
      SEQ_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (f_free) begin
          emit = 1'b1;
          if (done) begin
            state_next = SEQ_IDLE;
          end
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // Fields of the current fragment
  always_comb begin
    pos_end  = {1'b0, pos} + {1'b0, job.piece};
    lastp    = pos_end >= {1'b0, job.payload};
    e_status = job.status;
    e_ident  = 16'd0;
    e_fo     = 16'd0;
    e_flen   = 16'd0;
    e_last   = 1'b1;
    done     = 1'b1;
    priority if (job.status != ST_OK) begin
      // refused: one result, fields cleared
      e_last = 1'b1;
    end else if (!job.frag) begin
      e_ident = job.ident;
      e_fo    = job.offw;
      e_flen  = job.tlen;
    end else begin
      e_ident = job.ident;
      // offset added onto the incoming word with DF and MF cleared, bit 15 kept
      e_fo    = {3'b000, pos[15:3]} + (job.offw & ~(DF_MASK | MF_MASK));
      if (job.offw[FLAG_MF] || !lastp) begin
        e_fo = e_fo | MF_MASK;
      end
      e_flen  = lastp ? (job.payload - pos + HDR_LEN) : (job.piece + HDR_LEN);
      e_last  = lastp;
      done    = lastp;
    end
  end

  // Request registers and fixed part of the checksum
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job  <= q_data;
      pos  <= 16'd0;
      base <= SUM_W'({VER_IHL, q_data.tos}) + SUM_W'(q_data.ident)
            + SUM_W'({q_data.ttl, q_data.protocol}) + SUM_W'(q_data.addr_sum);
    end else if (emit) begin
      pos <= pos + job.piece;
    end
  end

  // Fragment stage
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (emit) begin
      f_valid <= 1'b1;
    end else if (o_free) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      f_status <= e_status;
      f_ident  <= e_ident;
      f_fo     <= e_fo;
      f_flen   <= e_flen;
      f_base   <= base;
      f_last   <= e_last;
    end
  end

  // Output register with checksum
  assign o_sum = f_base + SUM_W'(f_flen) + SUM_W'(f_fo);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (o_free) begin
      res.valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_valid && o_free) begin
      res.payload.status           <= f_status;
      res.payload.ident_out        <= f_ident;
      res.payload.flags_offset_out <= f_fo;
      res.payload.frag_total_len   <= f_flen;
      res.payload.header_checksum  <= (f_status == ST_OK) ? ~csum_fold(o_sum) : 16'd0;
      res.payload.last             <= f_last;
    end
  end

  a_refused_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.payload.status != ST_OK)
      |-> (res.payload.last && res.payload.header_checksum == 16'd0))
    else $error("refused request result not final or carries a checksum");

  a_mf_on_inner: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !f_last && f_status == ST_OK) |-> f_fo[FLAG_MF])
    else $error("inner fragment without MF");

endmodule

// ===== rtl/ipv4_fragment_header_generator.sv =====
// IPv4 fragment header generator. One header request (20-byte header, no options)
// enters on hdr; for each request the block gives one or more results on res, the
// last flagged by last. A locally sourced request takes the next identification
// number and keeps only DF; a forwarded one keeps its own. A request that fits the
// MTU gives one header; a larger one is refused (status 1) if DF is set, the MTU is
// below 28 or more than 64 fragments would be needed, otherwise it is split into
// pieces of (MTU-20) rounded down to 8 bytes, one header per piece with its
// offset, MF, length and checksum. Broadcast requests are refused when the
// interface cannot broadcast (status 2) or when they exceed the MTU (status 1).
// Throughput is set by the back-end sequencer: it loads a request from the queue,
// then gives one result per cycle while the fragment stage is free, and takes
// the next request only after the last result. The front end takes a request in
// any cycle in which the queue (QUEUE_DEPTH entries) has room; a loaded request
// passes the job register, the fragment stage and the output register to res.
// Write mtu (index 0) and broadcast_ok (index 1) only while the block is idle.
module ipv4_fragment_header_generator #(
  parameter int QUEUE_DEPTH = ipv4fhg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ipv4fhg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ipv4fhg_pkg::CFG_DATA_W-1:0] cfg_data,
  ipv4fhg_hdr_if.sink                       hdr,
  ipv4fhg_res_if.source                     res
);
  import ipv4fhg_pkg::*;

  logic [15:0] mtu;
  logic        broadcast_ok;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  job_t        q_in;
  job_t        q_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mtu          <= MTU_RESET;
      broadcast_ok <= BCAST_OK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MTU:      mtu          <= cfg_data[15:0];
        CFG_BCAST_OK: broadcast_ok <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  ipv4fhg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .mtu          (mtu),
    .broadcast_ok (broadcast_ok),
    .hdr          (hdr),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  ipv4fhg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  ipv4fhg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_out),
    .res     (res)
  );

endmodule
